// ----- hw/rtl/sorted_insert_and_merge_tables_defines.svh -----
// Assertion macros shared by the RTL of the sorted table block.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef SORTED_INSERT_AND_MERGE_TABLES_DEFINES_SVH
`define SORTED_INSERT_AND_MERGE_TABLES_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIMT_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/simt_pkg.sv -----
package simt_pkg;

	localparam int DEPTH_DEF = 32;

	localparam int KEY_W   = 31;
	localparam int PRICE_W = 32;
	localparam int TAG_W   = 16;

	localparam logic [1:0] CMD_INS_A = 2'd0;
	localparam logic [1:0] CMD_INS_B = 2'd1;
	localparam logic [1:0] CMD_MERGE = 2'd2;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_RECORD   = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [PRICE_W-1:0] price;
		logic [TAG_W-1:0]   tag;
	} rec_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [KEY_W-1:0]   key;
		logic [PRICE_W-1:0] price_cents;
		logic [TAG_W-1:0]   record_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [KEY_W-1:0]   key_res;
		logic [PRICE_W-1:0] price_cents_res;
		logic [TAG_W-1:0]   record_tag_res;
		logic               source_table;
		logic               last;
	} rsp_t;

endpackage

// ----- hw/rtl/simt_ram.sv -----
module simt_ram import simt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output rec_t                     rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  rec_t                     wr_data
);

	rec_t mem [DEPTH];
	rec_t rd_data_q;

	// Read data holds until the next read, so a waiting consumer keeps its operand.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/sorted_insert_and_merge_tables.sv -----
// Two sorted record tables, A and B, kept in ascending key order in two memories.
// Request channel (req_valid/req_ready/req): one beat is one command: insert into A,
// insert into B, or merge. Response channel (rsp_valid/rsp_ready/rsp) returns results.
// An insert answers with one beat (inserted or full) in the cycle after acceptance. The
// record is then placed by shifting entries whose key is not below its key up one slot
// per cycle through the memory port, holding the block until the slot is found; a
// rejected insert does not hold the block.
// A merge reads both table heads when accepted, then emits one record per cycle unless
// the receiver stalls, B first on equal keys, with last set on the final record; both
// tables are then empty. A merge of two empty tables answers with a single empty beat.
// The response sits in an output register; a new command is taken only when that register
// is empty or is read in the same cycle, so when the receiver stalls, the request side
// waits too and a merge pauses in place.
// Command code 3 is accepted and dropped without a response.
// Reset clears both counts and the output valid; the memories are not cleared.
`include "sorted_insert_and_merge_tables_defines.svh"

module sorted_insert_and_merge_tables import simt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_MRG  = 2'd2;

	logic [1:0]    state_q;
	logic          tbl_q;
	logic [AW-1:0] idx_q;
	rec_t          new_q;
	logic [CW-1:0] cnt_a_q, cnt_b_q, ia_q, ib_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          a_rd_en, b_rd_en, a_wr_en, b_wr_en;
	logic [AW-1:0] a_rd_addr, b_rd_addr, wr_addr;
	rec_t          wr_data, a_rd_data, b_rd_data;

	logic          slot_free, accept, is_ins, sel_b, ins_full, ins_go;
	logic          is_mrg, mrg_empty, mrg_go;
	logic [CW-1:0] cnt_sel;
	rec_t          shift_rd;
	logic          in_ins, place;
	logic          in_mrg, a_left, b_left, take_a, mrg_fire, mrg_last;
	logic [CW-1:0] ia_nxt, ib_nxt;
	logic [AW-1:0] ins_rd_addr;
	logic          rsp_load;
	rsp_t          rsp_d;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req_valid && req_ready;

	assign is_ins    = accept && (req.command == CMD_INS_A || req.command == CMD_INS_B);
	assign sel_b     = (req.command == CMD_INS_B);
	assign cnt_sel   = sel_b ? cnt_b_q : cnt_a_q;
	assign ins_full  = (cnt_sel == DEPTH_CNT);
	assign ins_go    = is_ins && !ins_full;

	assign is_mrg    = accept && (req.command == CMD_MERGE);
	assign mrg_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
	assign mrg_go    = is_mrg && !mrg_empty;

	// Insert: walk down from the top slot, moving each entry whose key is not below
	// the new key up by one, until the slot for the new record is found.
	assign in_ins   = (state_q == S_INS);
	assign shift_rd = tbl_q ? b_rd_data : a_rd_data;
	assign place    = (idx_q == '0) || (shift_rd.key < new_q.key);
	assign wr_addr  = idx_q;
	assign wr_data  = place ? new_q : shift_rd;
	assign a_wr_en  = in_ins && !tbl_q;
	assign b_wr_en  = in_ins && tbl_q;

	// Merge: each table's read data holds its current head; only the side that is
	// taken fetches its next entry.
	assign in_mrg   = (state_q == S_MRG);
	assign a_left   = (ia_q != cnt_a_q);
	assign b_left   = (ib_q != cnt_b_q);
	assign take_a   = a_left && (!b_left || (a_rd_data.key < b_rd_data.key));
	assign mrg_fire = in_mrg && slot_free;
	assign ia_nxt   = ia_q + CW'(take_a);
	assign ib_nxt   = ib_q + CW'(!take_a);
	assign mrg_last = (ia_nxt == cnt_a_q) && (ib_nxt == cnt_b_q);

	always_comb begin
		if (in_ins) begin
			ins_rd_addr = idx_q - AW'(2);
		end else begin
			ins_rd_addr = AW'(cnt_sel - CW'(1));
		end
	end

	always_comb begin
		a_rd_en   = 1'b0;
		b_rd_en   = 1'b0;
		a_rd_addr = ins_rd_addr;
		b_rd_addr = ins_rd_addr;
		priority if (mrg_go) begin
			a_rd_en   = 1'b1;
			b_rd_en   = 1'b1;
			a_rd_addr = '0;
			b_rd_addr = '0;
		end else if (in_mrg) begin
			a_rd_en   = mrg_fire && take_a;
			b_rd_en   = mrg_fire && !take_a;
			a_rd_addr = ia_nxt[AW-1:0];
			b_rd_addr = ib_nxt[AW-1:0];
		end else if (in_ins) begin
			a_rd_en = !place && !tbl_q;
			b_rd_en = !place && tbl_q;
		end else begin
			a_rd_en = ins_go && !sel_b && (cnt_sel != '0);
			b_rd_en = ins_go && sel_b && (cnt_sel != '0);
		end
	end

	simt_ram #(.DEPTH(DEPTH)) u_ram_a (
		.clk     (clk),
		.rd_en   (a_rd_en),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd_data),
		.wr_en   (a_wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	simt_ram #(.DEPTH(DEPTH)) u_ram_b (
		.clk     (clk),
		.rd_en   (b_rd_en),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd_data),
		.wr_en   (b_wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tbl_q   <= 1'b0;
			idx_q   <= '0;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ia_q    <= '0;
			ib_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ins_go) begin
						state_q <= S_INS;
						tbl_q   <= sel_b;
						idx_q   <= cnt_sel[AW-1:0];
						if (sel_b) begin
							cnt_b_q <= cnt_b_q + CW'(1);
						end else begin
							cnt_a_q <= cnt_a_q + CW'(1);
						end
					end else if (mrg_go) begin
						state_q <= S_MRG;
						ia_q    <= '0;
						ib_q    <= '0;
					end
				end
				S_INS: begin
					if (place) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q - AW'(1);
					end
				end
				S_MRG: begin
					if (mrg_fire) begin
						ia_q <= ia_nxt;
						ib_q <= ib_nxt;
						if (mrg_last) begin
							state_q <= S_IDLE;
							cnt_a_q <= '0;
							cnt_b_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ins_go) begin
			new_q.key   <= req.key;
			new_q.price <= req.price_cents;
			new_q.tag   <= req.record_tag;
		end
	end

	assign rsp_load = is_ins || (is_mrg && mrg_empty) || mrg_fire;

	always_comb begin
		rsp_d      = '0;
		rsp_d.last = 1'b1;
		priority if (mrg_fire) begin
			rsp_d.status          = ST_RECORD;
			rsp_d.key_res         = take_a ? a_rd_data.key : b_rd_data.key;
			rsp_d.price_cents_res = take_a ? a_rd_data.price : b_rd_data.price;
			rsp_d.record_tag_res  = take_a ? a_rd_data.tag : b_rd_data.tag;
			rsp_d.source_table    = !take_a;
			rsp_d.last            = mrg_last;
		end else if (is_mrg) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.status = ins_full ? ST_FULL : ST_INSERTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SIMT_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_a_q <= DEPTH_CNT && cnt_b_q <= DEPTH_CNT,
		"table count exceeds depth")
	`SIMT_ASSERT_IMPLY(a_mrg_ptrs, in_mrg,
		ia_q <= cnt_a_q && ib_q <= cnt_b_q && (a_left || b_left),
		"merge pointer outside table contents")
	`SIMT_ASSERT_NEXT(a_mrg_clear, mrg_fire && mrg_last,
		cnt_a_q == '0 && cnt_b_q == '0 && state_q == S_IDLE,
		"tables not emptied after final merged record")
	`SIMT_ASSERT_IMPLY(a_no_overwrite, rsp_valid_q && !rsp_ready, !rsp_load,
		"response register overwritten while stalled")

endmodule
